/* sv/buddy_page_allocator_top_defines.svh */
// Assertion macros for the buddy page allocator.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("buddy allocator check failed");
`define BPA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("buddy allocator sequence check failed");
`else
`define BPA_ASSERT(label, prop)
`define BPA_ASSERT_NEXT(label, pre, post)
`endif
`endif

/* sv/bpa_pkg.sv */
// Shared types, codes and helpers for the buddy page allocator.
// No dependencies.
`timescale 1ns / 1ps
package bpa_pkg;

    localparam int DEF_TOP_ORDER     = 10;
    localparam int DEF_POOL_CAPACITY = 4096;

    localparam int MODE_W = 2;
    localparam int IDX_W  = 12;
    localparam int CNT_W  = 13;
    localparam int REQ_W  = 4;

    localparam logic [CNT_W-1:0] POOL_PAGES_RST = 13'd4096;

    localparam logic [MODE_W-1:0] MODE_INIT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FAIL     = 2'd1,
        ST_BAD_FREE = 2'd2
    } bpa_status_t;

    typedef struct packed {
        logic               done;
        bpa_status_t        status;
        logic [IDX_W-1:0]   block_index;
        logic [CNT_W-1:0]   pages_avail;
    } bpa_result_t;

    // Smallest order whose block covers count pages; zero counts as one.
    function automatic logic [REQ_W-1:0] order_of(input logic [CNT_W-1:0] count);
        logic [CNT_W-1:0] v;
        logic [REQ_W-1:0] o;
        v = (count > 13'd1) ? (count - 13'd1) : '0;
        o = '0;
        for (int b = 0; b < CNT_W; b++)
        begin
            if (v[b])
            begin
                o = REQ_W'(b + 1);
            end
        end
        return o;
    endfunction

endpackage

/* sv/buddy_page_allocator_top.sv */
// Top level of the buddy page allocator: config register, sequencer, tag store, result register.
// Depends on bpa_pkg, bpa_tag_ram, bpa_ctrl and buddy_page_allocator_top_defines.svh.
`timescale 1ns / 1ps
`include "buddy_page_allocator_top_defines.svh"
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  -------------------------------------
//  command   start & !busy                mode, page_index, page_count
//  result    done (one-cycle strobe)      status, block_index, pages_avail
//  config    cfg_valid & cfg_ready        cfg_data (pool_pages)
//
//  Work per item: mode 3 and rejected items go from dispatch to the result;
//  alloc does a strided scan of the tag store for the lowest free block of
//  the chosen order, one read a cycle, then one split step per order above
//  the request; free does the overlap scan, then a read and a check per
//  ancestor and per merge step. Init sweeps the tag store, then files one
//  block a cycle. After reset the same clearing pass runs, busy high.
//  Results cannot be stalled; each shows for one cycle with done.
//
module buddy_page_allocator_top import bpa_pkg::*; #(
    parameter int TOP_ORDER     = DEF_TOP_ORDER,
    parameter int POOL_CAPACITY = DEF_POOL_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [MODE_W-1:0] mode,
    input  logic [IDX_W-1:0]  page_index,
    input  logic [CNT_W-1:0]  page_count,
    output logic              done,
    output logic [1:0]        status,
    output logic [IDX_W-1:0]  block_index,
    output logic [CNT_W-1:0]  pages_avail,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data
);

    localparam int IW = $clog2(POOL_CAPACITY);
    localparam int TW = $clog2(TOP_ORDER + 2);

    // Pool size register; always ready, read only when an init item dispatches.
    logic [CNT_W-1:0] pool_pages_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_pages_reg <= POOL_PAGES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pool_pages_reg <= cfg_data;
        end
    end

    // Tag store: per page, zero or one plus the order of the free block it heads.
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [TW-1:0] ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [TW-1:0] ram_rdata;

    bpa_tag_ram #(
        .DEPTH (POOL_CAPACITY),
        .AW    (IW),
        .DW    (TW)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bpa_result_t res;

    bpa_ctrl #(
        .TOP_ORDER     (TOP_ORDER),
        .POOL_CAPACITY (POOL_CAPACITY),
        .IW            (IW),
        .TW            (TW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .mode       (mode),
        .page_index (page_index),
        .page_count (page_count),
        .pool_pages (pool_pages_reg),
        .busy       (busy),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // Output register: register the finished item; done shows for exactly one cycle.
    logic             done_reg;
    bpa_status_t      status_reg;
    logic [IDX_W-1:0] block_index_reg;
    logic [CNT_W-1:0] pages_avail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            status_reg      <= res.status;
            block_index_reg <= res.block_index;
            pages_avail_reg <= res.pages_avail;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign block_index = block_index_reg;
    assign pages_avail = pages_avail_reg;

    `BPA_ASSERT_NEXT(a_done_single, done, !done)
    `BPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `BPA_ASSERT(a_fail_no_index, (done && (status != ST_OK)) |-> (block_index == '0))

endmodule

/* sv/bpa_tag_ram.sv */
// Block tag store: one write port, one read port, registered read data.
// Depends on no package.
`timescale 1ns / 1ps
module bpa_tag_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/bpa_ctrl.sv */
// Sequencer of the buddy allocator: clear, carve, alloc search and split, free check and merge.
// Depends on bpa_pkg; drives the tag store bpa_tag_ram.
`timescale 1ns / 1ps
module bpa_ctrl import bpa_pkg::*; #(
    parameter int TOP_ORDER     = DEF_TOP_ORDER,
    parameter int POOL_CAPACITY = DEF_POOL_CAPACITY,
    parameter int IW            = $clog2(POOL_CAPACITY),
    parameter int TW            = $clog2(TOP_ORDER + 2)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MODE_W-1:0] mode,
    input  logic [IDX_W-1:0]  page_index,
    input  logic [CNT_W-1:0]  page_count,
    input  logic [CNT_W-1:0]  pool_pages,
    output logic              busy,
    output bpa_result_t       res,
    output logic              ram_we,
    output logic [IW-1:0]     ram_waddr,
    output logic [TW-1:0]     ram_wdata,
    output logic              ram_re,
    output logic [IW-1:0]     ram_raddr,
    input  logic [TW-1:0]     ram_rdata
);

    localparam int XW   = ((IW > IDX_W) ? IW : IDX_W) + 1;
    localparam int OW   = (TOP_ORDER > 1) ? $clog2(TOP_ORDER + 1) : 1;
    localparam int NORD = TOP_ORDER + 1;
    localparam logic [XW-1:0] CAP_X = XW'(POOL_CAPACITY);
    localparam logic [OW-1:0] TOP_O = OW'(TOP_ORDER);

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b0000_0000_0001,
        S_IDLE     = 12'b0000_0000_0010,
        S_DISP     = 12'b0000_0000_0100,
        S_CARVE    = 12'b0000_0000_1000,
        S_AFIND    = 12'b0000_0001_0000,
        S_ASPLIT   = 12'b0000_0010_0000,
        S_FRANGE   = 12'b0000_0100_0000,
        S_FANC_RD  = 12'b0000_1000_0000,
        S_FANC_CHK = 12'b0001_0000_0000,
        S_MRG_RD   = 12'b0010_0000_0000,
        S_MRG_CHK  = 12'b0100_0000_0000,
        S_FIN      = 12'b1000_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic              init_reg, init_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [XW-1:0]     idx_reg, idx_next;
    logic [REQ_W-1:0]  want_reg, want_next;
    logic [XW-1:0]     ext_reg, ext_next;
    logic [XW-1:0]     pos_reg, pos_next;
    logic [XW-1:0]     end_reg, end_next;
    logic              pend_reg, pend_next;
    logic [XW-1:0]     paddr_reg, paddr_next;
    logic [OW-1:0]     oc_reg, oc_next;
    logic [OW-1:0]     k_reg, k_next;
    logic [XW-1:0]     cur_reg, cur_next;
    logic [XW-1:0]     cnt_reg [NORD];
    logic [XW-1:0]     cnt_next [NORD];
    logic [XW-1:0]     free_reg, free_next;
    bpa_status_t       status_reg, status_next;
    logic [XW-1:0]     where_reg, where_next;

    function automatic logic [XW-1:0] pow2(input logic [OW-1:0] o);
        return XW'(1) << o;
    endfunction

    // Smallest nonempty order at or above the request.
    logic          afound;
    logic [OW-1:0] apick;
    always_comb
    begin
        afound = 1'b0;
        apick  = '0;
        for (int k = 0; k < NORD; k++)
        begin
            if (!afound && (k >= int'(want_reg)) && (cnt_reg[k] != '0))
            begin
                afound = 1'b1;
                apick  = OW'(k);
            end
        end
    end

    // Largest aligned block that fits at the carve position.
    logic [OW-1:0] cpick;
    always_comb
    begin
        cpick = '0;
        for (int k = 0; k < NORD; k++)
        begin
            if (((pos_reg & (pow2(OW'(k)) - XW'(1))) == '0)
                && ((pos_reg + pow2(OW'(k))) <= ext_reg))
            begin
                cpick = OW'(k);
            end
        end
    end

    logic [OW-1:0] want_o;
    logic [XW-1:0] bud;
    logic [XW-1:0] ext_in;
    assign want_o = OW'(want_reg);
    assign bud    = cur_reg ^ pow2(oc_reg);
    assign ext_in = XW'(pool_pages);

    always_comb
    begin
        logic hit;
        state_next  = state_reg;
        init_next   = init_reg;
        mode_next   = mode_reg;
        idx_next    = idx_reg;
        want_next   = want_reg;
        ext_next    = ext_reg;
        pos_next    = pos_reg;
        end_next    = end_reg;
        pend_next   = 1'b0;
        paddr_next  = paddr_reg;
        oc_next     = oc_reg;
        k_next      = k_reg;
        cur_next    = cur_reg;
        cnt_next    = cnt_reg;
        free_next   = free_reg;
        status_next = status_reg;
        where_next  = where_reg;
        ram_we      = 1'b0;
        ram_waddr   = cur_reg[IW-1:0];
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = pos_reg[IW-1:0];
        res         = '0;
        hit         = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[IW-1:0];
                pos_next  = pos_reg + XW'(1);
                if (pos_reg == CAP_X - XW'(1))
                begin
                    pos_next   = '0;
                    state_next = init_reg ? S_CARVE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    idx_next   = XW'(page_index);
                    want_next  = order_of(page_count);
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                status_next = ST_OK;
                where_next  = '0;
                state_next  = S_FIN;
                case (mode_reg)
                    MODE_INIT:
                    begin
                        ext_next  = (ext_in > CAP_X) ? CAP_X : ext_in;
                        for (int k = 0; k < NORD; k++)
                        begin
                            cnt_next[k] = '0;
                        end
                        free_next  = '0;
                        pos_next   = '0;
                        init_next  = 1'b1;
                        state_next = S_CLEAR;
                    end
                    MODE_ALLOC:
                    begin
                        if ((int'(want_reg) > TOP_ORDER) || !afound)
                        begin
                            status_next = ST_FAIL;
                        end
                        else
                        begin
                            oc_next    = apick;
                            pos_next   = '0;
                            end_next   = CAP_X;
                            state_next = S_AFIND;
                        end
                    end
                    MODE_FREE:
                    begin
                        if (int'(want_reg) > TOP_ORDER)
                        begin
                            status_next = ST_FAIL;
                        end
                        else if (((idx_reg & (pow2(want_o) - XW'(1))) != '0)
                                 || ((idx_reg + pow2(want_o)) > ext_reg))
                        begin
                            status_next = ST_BAD_FREE;
                        end
                        else
                        begin
                            pos_next   = idx_reg;
                            end_next   = idx_reg + pow2(want_o);
                            oc_next    = want_o;
                            cur_next   = idx_reg;
                            state_next = S_FRANGE;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_CARVE:
            begin
                if (pos_reg >= ext_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = pos_reg[IW-1:0];
                    ram_wdata       = TW'(cpick) + TW'(1);
                    cnt_next[cpick] = cnt_reg[cpick] + XW'(1);
                    free_next       = free_reg + pow2(cpick);
                    pos_next        = pos_reg + pow2(cpick);
                end
            end
            S_AFIND:
            begin
                hit = pend_reg && (ram_rdata == (TW'(oc_reg) + TW'(1)));
                if (hit)
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = paddr_reg[IW-1:0];
                    cnt_next[oc_reg] = cnt_reg[oc_reg] - XW'(1);
                    free_next        = free_reg - pow2(oc_reg);
                    cur_next         = paddr_reg;
                    state_next       = S_ASPLIT;
                end
                else if (pos_reg < end_reg)
                begin
                    ram_re     = 1'b1;
                    pend_next  = 1'b1;
                    paddr_next = pos_reg;
                    pos_next   = pos_reg + pow2(oc_reg);
                end
                else if (!pend_reg)
                begin
                    status_next = ST_FAIL;
                    state_next  = S_FIN;
                end
            end
            S_ASPLIT:
            begin
                if (oc_reg == want_o)
                begin
                    where_next = cur_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    ram_we                   = 1'b1;
                    ram_waddr                = IW'(cur_reg + pow2(oc_reg - OW'(1)));
                    ram_wdata                = TW'(oc_reg);
                    cnt_next[oc_reg - OW'(1)] = cnt_reg[oc_reg - OW'(1)] + XW'(1);
                    free_next                = free_reg + pow2(oc_reg - OW'(1));
                    oc_next                  = oc_reg - OW'(1);
                end
            end
            S_FRANGE:
            begin
                if (pend_reg && (ram_rdata != '0))
                begin
                    status_next = ST_BAD_FREE;
                    state_next  = S_FIN;
                end
                else if (pos_reg < end_reg)
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    pos_next  = pos_reg + XW'(1);
                end
                else if (!pend_reg)
                begin
                    if (oc_reg == TOP_O)
                    begin
                        state_next = S_MRG_RD;
                    end
                    else
                    begin
                        k_next     = oc_reg + OW'(1);
                        state_next = S_FANC_RD;
                    end
                end
            end
            S_FANC_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = IW'(idx_reg & ~(pow2(k_reg) - XW'(1)));
                state_next = S_FANC_CHK;
            end
            S_FANC_CHK:
            begin
                if (ram_rdata == (TW'(k_reg) + TW'(1)))
                begin
                    status_next = ST_BAD_FREE;
                    state_next  = S_FIN;
                end
                else if (k_reg == TOP_O)
                begin
                    state_next = S_MRG_RD;
                end
                else
                begin
                    k_next     = k_reg + OW'(1);
                    state_next = S_FANC_RD;
                end
            end
            S_MRG_RD:
            begin
                if ((oc_reg == TOP_O) || ((bud + pow2(oc_reg)) > ext_reg))
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = cur_reg[IW-1:0];
                    ram_wdata        = TW'(oc_reg) + TW'(1);
                    cnt_next[oc_reg] = cnt_reg[oc_reg] + XW'(1);
                    free_next        = free_reg + pow2(oc_reg);
                    state_next       = S_FIN;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = bud[IW-1:0];
                    state_next = S_MRG_CHK;
                end
            end
            S_MRG_CHK:
            begin
                if (ram_rdata == (TW'(oc_reg) + TW'(1)))
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = bud[IW-1:0];
                    cnt_next[oc_reg] = cnt_reg[oc_reg] - XW'(1);
                    free_next        = free_reg - pow2(oc_reg);
                    cur_next         = cur_reg & ~pow2(oc_reg);
                    oc_next          = oc_reg + OW'(1);
                    state_next       = S_MRG_RD;
                end
                else
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = cur_reg[IW-1:0];
                    ram_wdata        = TW'(oc_reg) + TW'(1);
                    cnt_next[oc_reg] = cnt_reg[oc_reg] + XW'(1);
                    free_next        = free_reg + pow2(oc_reg);
                    state_next       = S_FIN;
                end
            end
            S_FIN:
            begin
                res.done        = 1'b1;
                res.status      = status_reg;
                res.block_index = IDX_W'(where_reg);
                res.pages_avail = CNT_W'(free_reg);
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            init_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            pos_reg   <= '0;
            ext_reg   <= '0;
            free_reg  <= '0;
            for (int k = 0; k < NORD; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
            ext_reg   <= ext_next;
            free_reg  <= free_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        idx_reg    <= idx_next;
        want_reg   <= want_next;
        end_reg    <= end_next;
        paddr_reg  <= paddr_next;
        oc_reg     <= oc_next;
        k_reg      <= k_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        where_reg  <= where_next;
    end

endmodule

/* bench/buddy_page_allocator_checker.sv */
// Checker for the buddy page allocator: watches command, config and result channels,
// keeps its own buddy-system model and compares every result. Depends on bpa_pkg.
`timescale 1ns / 1ps
module buddy_page_allocator_checker import bpa_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [MODE_W-1:0] mode,
    input  logic [IDX_W-1:0]  page_index,
    input  logic [CNT_W-1:0]  page_count,
    input  logic              done,
    input  logic [1:0]        status,
    input  logic [IDX_W-1:0]  block_index,
    input  logic [CNT_W-1:0]  pages_avail,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data,
    output int                fail_count,
    output int                pending_count
);
    localparam int TOPO = DEF_TOP_ORDER;
    localparam int CAP  = DEF_POOL_CAPACITY;

    typedef struct {
        bpa_status_t      st;
        logic [IDX_W-1:0] blk;
        logic [CNT_W-1:0] total;
    } alloc_result_t;

    logic [3:0]  head_tag [CAP];
    int          per_order [TOPO+1];
    int          pool_cfg;
    int          extent;
    alloc_result_t expected_results [$];

    function automatic int order_for(int count);
        int o;
        o = 0;
        if (count == 0)
        begin
            count = 1;
        end
        while (o < 14 && (1 << o) < count)
        begin
            o++;
        end
        return o;
    endfunction

    function automatic int free_total();
        int s;
        s = 0;
        for (int k = 0; k <= TOPO; k++)
        begin
            s += per_order[k] << k;
        end
        return s;
    endfunction

    function automatic void file_blk(int idx, int o);
        head_tag[idx] = 4'(o + 1);
        per_order[o]++;
    endfunction

    function automatic void carve_pool();
        int pos;
        int o;
        pos = 0;
        foreach (head_tag[i]) head_tag[i] = '0;
        foreach (per_order[i]) per_order[i] = 0;
        extent = (pool_cfg > CAP) ? CAP : pool_cfg;
        while (pos < extent)
        begin
            o = TOPO;
            while (o > 0 && ((pos & ((1 << o) - 1)) != 0 || pos + (1 << o) > extent))
            begin
                o--;
            end
            file_blk(pos, o);
            pos += 1 << o;
        end
    endfunction

    function automatic bpa_status_t take_block(int count, output int where);
        int want;
        int o;
        int p;
        where = 0;
        want = order_for(count);
        if (want > TOPO)
        begin
            return ST_FAIL;
        end
        for (o = want; o <= TOPO; o++)
        begin
            if (per_order[o] != 0)
            begin
                break;
            end
        end
        if (o > TOPO)
        begin
            return ST_FAIL;
        end
        for (p = 0; p < CAP; p++)
        begin
            if (head_tag[p] == o + 1)
            begin
                break;
            end
        end
        if (p >= CAP)
        begin
            return ST_FAIL;
        end
        head_tag[p] = '0;
        per_order[o]--;
        while (o > want)
        begin
            o--;
            file_blk(p + (1 << o), o);
        end
        where = p;
        return ST_OK;
    endfunction

    function automatic bpa_status_t return_block(int idx, int count);
        int o;
        int size;
        int cur;
        int bud;
        o = order_for(count);
        if (o > TOPO)
        begin
            return ST_FAIL;
        end
        size = 1 << o;
        if ((idx & (size - 1)) != 0 || idx + size > extent)
        begin
            return ST_BAD_FREE;
        end
        for (int p = idx; p < idx + size; p++)
        begin
            if (head_tag[p] != 0)
            begin
                return ST_BAD_FREE;
            end
        end
        for (int k = o + 1; k <= TOPO; k++)
        begin
            if (head_tag[idx & ~((1 << k) - 1)] == k + 1)
            begin
                return ST_BAD_FREE;
            end
        end
        cur = idx;
        while (o < TOPO)
        begin
            bud = cur ^ (1 << o);
            if (bud + (1 << o) > extent || head_tag[bud] != o + 1)
            begin
                break;
            end
            head_tag[bud] = '0;
            per_order[o]--;
            if (bud < cur)
            begin
                cur = bud;
            end
            o++;
        end
        file_blk(cur, o);
        return ST_OK;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t r;
        alloc_result_t e;
        int where;
        if (!rst_n)
        begin
            foreach (head_tag[i]) head_tag[i] = '0;
            foreach (per_order[i]) per_order[i] = 0;
            pool_cfg = int'(POOL_PAGES_RST);
            extent = 0;
            fail_count <= 0;
            expected_results.delete();
        end
        else
        begin
            // Compare first: a result never appears in the cycle its item is taken.
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result status=%0d block_index=%0d pages_avail=%0d",
                           status, block_index, pages_avail);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (status != e.st || block_index != e.blk || pages_avail != e.total)
                    begin
                        if (status != e.st)
                            $error("status expected %0d actual %0d", e.st, status);
                        if (block_index != e.blk)
                            $error("block_index expected %0d actual %0d", e.blk, block_index);
                        if (pages_avail != e.total)
                            $error("pages_avail expected %0d actual %0d", e.total, pages_avail);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                pool_cfg = int'(cfg_data);
            end
            if (start && !busy)
            begin
                where = 0;
                r.st = ST_OK;
                if (mode == MODE_INIT)
                    carve_pool();
                else if (mode == MODE_ALLOC)
                    r.st = take_block(int'(page_count), where);
                else if (mode == MODE_FREE)
                    r.st = return_block(int'(page_index), int'(page_count));
                r.blk = IDX_W'(where);
                r.total = CNT_W'(free_total());
                expected_results.push_back(r);
            end
        end
    end
endmodule

/* bench/buddy_page_allocator_top_test.sv */
// Testbench top for the buddy page allocator: clock, reset, command and config stimulus.
// Depends on bpa_pkg, buddy_page_allocator_top and buddy_page_allocator_checker.
`timescale 1ns / 1ps
module buddy_page_allocator_top_test;
    import bpa_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  page_index;
    logic [CNT_W-1:0]  page_count;
    logic              done;
    logic [1:0]        status;
    logic [IDX_W-1:0]  block_index;
    logic [CNT_W-1:0]  pages_avail;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data;
    int                fail_count;
    int                pending_count;

    // Blocks handed out and not yet returned, so frees are mostly well formed.
    int held_index [$];
    int held_count [$];
    int hold_off_pct;

    buddy_page_allocator_top dut (.*);

    buddy_page_allocator_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Generous cap: inits sweep the whole tag store, and an alloc from an order-0 free block can scan it page by page.
    initial
    begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end

    // Present one command and hold it until the block takes it; the block is
    // busy for the cycle after the drop, so the extra edge costs no rate.
    task automatic issue(input logic [MODE_W-1:0] m, input int idx, input int cnt);
        while ($urandom_range(99) < hold_off_pct)
            @(posedge clk);
        start      <= 1'b1;
        mode       <= m;
        page_index <= IDX_W'(idx);
        page_count <= CNT_W'(cnt);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Drain expectations, let the block settle, then write the pool size.
    task automatic set_pool(input int pages);
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CNT_W'(pages);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Take a block and remember it when the allocation would succeed.
    task automatic grab(input int cnt);
        issue(MODE_ALLOC, 0, cnt);
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        if (status == ST_OK)
        begin
            held_index.push_back(block_index);
            held_count.push_back(cnt);
        end
    endtask

    // Return a random held block, dropping it from the list.
    task automatic give_back();
        int k;
        k = $urandom_range(held_index.size() - 1);
        issue(MODE_FREE, held_index[k], held_count[k]);
        held_index.delete(k);
        held_count.delete(k);
    endtask

    initial
    begin
        int r;
        int pool;
        start = 1'b0; mode = '0; page_index = '0; page_count = '0;
        cfg_valid = 1'b0; cfg_data = '0;
        hold_off_pct = 18;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: free before init, odd modes, extremes of every field.
        issue(MODE_FREE, 0, 1);
        issue(MODE_NONE, 12'hFFF, 13'h1FFF);
        issue(MODE_INIT, 0, 0);
        issue(MODE_ALLOC, 0, 0);
        issue(MODE_ALLOC, 0, 1024);
        issue(MODE_ALLOC, 0, 1025);
        issue(MODE_ALLOC, 0, 13'h1FFF);
        issue(MODE_FREE, 0, 13'h1FFF);
        issue(MODE_FREE, 1, 2);
        issue(MODE_FREE, 1024, 1024);
        issue(MODE_FREE, 1024, 1024);
        issue(MODE_FREE, 12'hFFF, 1);
        issue(MODE_FREE, 0, 0);
        issue(MODE_ALLOC, 0, 3);
        issue(MODE_ALLOC, 0, 4096);
        set_pool(0);
        issue(MODE_INIT, 0, 0);
        issue(MODE_ALLOC, 0, 1);
        set_pool(13'h1FFF);
        issue(MODE_INIT, 0, 0);
        set_pool(4095);
        issue(MODE_INIT, 0, 0);
        issue(MODE_FREE, 4094, 2);

        // Random phases over several pool sizes, small pools first.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: pool = 1;
                1: pool = $urandom_range(2, 64);
                2: pool = $urandom_range(65, 600);
                3: pool = 4096;
                4: pool = $urandom_range(1, 8191);
                default: pool = 4096;
            endcase
            set_pool(pool);
            held_index.delete();
            held_count.delete();
            hold_off_pct = (phase == 3) ? 0 : 18;
            issue(MODE_INIT, 0, 0);
            for (int n = 0; n < 120; n++)
            begin
                r = $urandom_range(99);
                if (r < 45)
                    grab($urandom_range(99) < 85 ? $urandom_range(0, 16)
                                                  : $urandom_range(0, 8191));
                else if (r < 85 && held_index.size() != 0)
                    give_back();
                else if (r < 93)
                    issue(MODE_FREE, $urandom_range(4095), $urandom_range(8191));
                else if (r < 97)
                    issue(MODE_NONE, $urandom_range(4095), $urandom_range(8191));
                else
                    issue(MODE_INIT, $urandom, $urandom);
                if (r >= 97)
                begin
                    held_index.delete();
                    held_count.delete();
                end
            end
        end

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+sv
sv/bpa_pkg.sv
sv/bpa_tag_ram.sv
sv/bpa_ctrl.sv
sv/buddy_page_allocator_top.sv
bench/buddy_page_allocator_checker.sv
bench/buddy_page_allocator_top_test.sv
